// ===== rtl/core/ffba_pkg.sv =====
// Shared constants, field widths and result codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

	// Arena defaults
	localparam int ARENA_GRANULES = 1024;
	localparam int GRANULE_BYTES  = 16;
	localparam int GRANULE_LOG2   = $clog2(GRANULE_BYTES);

	// Field widths of the request, response and configuration beats
	localparam int KIND_W    = 1;
	localparam int BYTES_W   = 15;
	localparam int GRANULE_W = 10;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 11;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/ffba_req_if.sv =====
// Request channel of the allocator: valid/ready handshake with the request fields.
`default_nettype none
interface ffba_req_if;
	logic                             valid;
	logic                             ready;
	logic [ffba_pkg::KIND_W-1:0]      kind;
	logic [ffba_pkg::BYTES_W-1:0]     request_bytes;
	logic [ffba_pkg::GRANULE_W-1:0]   payload_granule;

	modport source (output valid, kind, request_bytes, payload_granule, input ready);
	modport sink   (input valid, kind, request_bytes, payload_granule, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffba_rsp_if.sv =====
// Response channel of the allocator: valid/ready handshake with the result fields.
`default_nettype none
interface ffba_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic [ffba_pkg::GRANULE_W-1:0]   granted_granule;
	logic [ffba_pkg::STATUS_W-1:0]    status;

	modport source (output valid, ok, granted_granule, status, input ready);
	modport sink   (input valid, ok, granted_granule, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// First-fit block allocator with coalescing over a header memory of one entry per granule.
//
//  channel  direction  beat contents                                   handshake
//  req      in         kind, request_bytes, payload_granule            valid/ready
//  rsp      out        ok, granted_granule, status                     valid/ready
//  cfg      in         cfg_data (arena size in granules)               cfg_we only
//
// An allocate walks the block headers from the start of the arena and splits a block that is larger
// than needed. A free checks the freed header and the next one, then scans the headers before it.
// The header memory has a single read port: one header is read per cycle.
// After reset and after every cfg write, a clearing pass rewrites every header memory entry; no request
// is taken meanwhile. A stalled response waits in the output register while the next request is taken;
// that request then waits to deliver its own beat.
`default_nettype none
module first_fit_block_allocator_core #(
	parameter int ARENA_GRANULES = ffba_pkg::ARENA_GRANULES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	ffba_req_if.sink                          req,
	ffba_rsp_if.source                        rsp,
	input  wire logic                         cfg_we,
	input  wire logic [ffba_pkg::CFG_W-1:0]   cfg_data
);

	localparam int AW   = (ARENA_GRANULES > 2) ? $clog2(ARENA_GRANULES) : 1;
	localparam int CW   = AW + 1;
	localparam int HDRW = AW + 2;
	localparam int BSW  = ffba_pkg::BYTES_W + 1;
	localparam int RW   = BSW - ffba_pkg::GRANULE_LOG2;
	localparam int XW   = ((RW > CW) ? RW : CW) + 1;
	localparam int GW   = ffba_pkg::GRANULE_W;
	localparam int HW   = (GW > CW) ? GW : CW;
	localparam int GXW  = (GW > CW) ? GW : CW;
	localparam int VW   = (ffba_pkg::CFG_W > CW) ? ffba_pkg::CFG_W : CW;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b00_0000_0001,
		ST_IDLE    = 10'b00_0000_0010,
		ST_A_CHK   = 10'b00_0000_0100,
		ST_A_SPLIT = 10'b00_0000_1000,
		ST_F_CHKH  = 10'b00_0001_0000,
		ST_F_CHKN  = 10'b00_0010_0000,
		ST_F_SCAN  = 10'b00_0100_0000,
		ST_F_WPREV = 10'b00_1000_0000,
		ST_F_WHDR  = 10'b01_0000_0000,
		ST_RESP    = 10'b10_0000_0000
	} state_t;

	function automatic logic [GW-1:0] grant_of(input logic [AW-1:0] hdr);
		logic [GXW-1:0] s;
		s = GXW'(hdr) + GXW'(1);
		return s[GW-1:0];
	endfunction

	// Header memory: {valid, busy, payload size}
	logic [HDRW-1:0] hdr_mem [ARENA_GRANULES];
	logic [HDRW-1:0] rd_q;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [HDRW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hdr_mem[wr_addr] <= wr_data;
		end
		rd_q <= hdr_mem[rd_addr];
	end

	state_t                        st_q, st_d;
	logic [AW-1:0]                 clr_q, clr_d;
	logic [CW-1:0]                 arena_q;
	logic [CW-1:0]                 pos_q, pos_d;
	logic [CW-1:0]                 h_q, h_d;
	logic [RW-1:0]                 req_q, req_d;
	logic [AW-1:0]                 hsz_q, hsz_d;
	logic [AW-1:0]                 psz_q, psz_d;
	logic [AW-1:0]                 nh_q, nh_d;
	logic                          merge_prev_q, merge_prev_d;
	logic                          res_ok_q, res_ok_d;
	logic [GW-1:0]                 res_gr_q, res_gr_d;
	logic [ffba_pkg::STATUS_W-1:0] res_st_q, res_st_d;
	logic                          rsp_valid_q;
	logic                          rsp_ok_q;
	logic [GW-1:0]                 rsp_gr_q;
	logic [ffba_pkg::STATUS_W-1:0] rsp_st_q;

	// Fields of the header just read
	logic          hv, hb;
	logic [AW-1:0] hs;
	assign hv = rd_q[AW+1];
	assign hb = rd_q[AW];
	assign hs = rd_q[AW-1:0];

	// Shared walk adder: start of the block after the one whose header was read
	logic [CW-1:0] walk_base, walk_next;
	assign walk_base = (st_q == ST_F_CHKH) ? h_q : pos_q;
	assign walk_next = walk_base + CW'(hs) + CW'(1);

	logic [XW-1:0] szx, reqx, nhx, splitx;
	logic          fit_split, fit_exact;
	assign szx       = XW'(hs);
	assign reqx      = XW'(req_q);
	assign fit_split = szx >= reqx + XW'(1);
	assign fit_exact = szx == reqx;
	assign nhx       = XW'(pos_q) + szx - reqx;
	assign splitx    = szx - reqx - XW'(1);

	logic [BSW-1:0] bsum;
	logic [RW-1:0]  req_gran;
	assign bsum     = BSW'(req.request_bytes) + BSW'(ffba_pkg::GRANULE_BYTES - 1);
	assign req_gran = bsum[BSW-1:ffba_pkg::GRANULE_LOG2];

	logic [HW-1:0] hx;
	logic          free_addr_bad;
	assign hx            = HW'(req.payload_granule) - HW'(1);
	assign free_addr_bad = (req.payload_granule == '0) || (hx >= HW'(arena_q));

	logic [CW-1:0] arena_m1;
	logic [AW:0]   merge_sum;
	logic          slot_free;
	assign arena_m1  = arena_q - CW'(1);
	assign merge_sum = (AW+1)'(hs) + (AW+1)'(hsz_q) + (AW+1)'(1);
	assign slot_free = !rsp_valid_q || rsp.ready;

	assign req.ready = (st_q == ST_IDLE) && !cfg_we;

	always_comb begin
		st_d         = st_q;
		clr_d        = clr_q;
		pos_d        = pos_q;
		h_d          = h_q;
		req_d        = req_q;
		hsz_d        = hsz_q;
		psz_d        = psz_q;
		nh_d         = nh_q;
		merge_prev_d = merge_prev_q;
		res_ok_d     = res_ok_q;
		res_gr_d     = res_gr_q;
		res_st_d     = res_st_q;
		rd_addr      = pos_q[AW-1:0];
		wr_en        = 1'b0;
		wr_addr      = pos_q[AW-1:0];
		wr_data      = '0;
		case (st_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q == '0) ? {2'b10, arena_m1[AW-1:0]} : '0;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(ARENA_GRANULES - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					res_ok_d     = 1'b0;
					res_gr_d     = '0;
					merge_prev_d = 1'b0;
					if (req.kind == ffba_pkg::KIND_ALLOC) begin
						req_d = req_gran;
						if (req.request_bytes == '0) begin
							res_st_d = ffba_pkg::STATUS_BAD_SIZE;
							st_d     = ST_RESP;
						end else begin
							rd_addr = '0;
							pos_d   = '0;
							st_d    = ST_A_CHK;
						end
					end else begin
						if (free_addr_bad) begin
							res_st_d = ffba_pkg::STATUS_NOT_ALLOC;
							st_d     = ST_RESP;
						end else begin
							h_d     = hx[CW-1:0];
							rd_addr = hx[AW-1:0];
							st_d    = ST_F_CHKH;
						end
					end
				end
			end
			ST_A_CHK: begin
				if (!hv) begin
					res_st_d = ffba_pkg::STATUS_NO_SPACE;
					st_d     = ST_RESP;
				end else if (!hb && fit_split) begin
					// The head stays free; the tail becomes the granted block.
					wr_en   = 1'b1;
					wr_data = {2'b10, splitx[AW-1:0]};
					nh_d    = nhx[AW-1:0];
					st_d    = ST_A_SPLIT;
				end else if (!hb && fit_exact) begin
					wr_en    = 1'b1;
					wr_data  = {2'b11, hs};
					res_ok_d = 1'b1;
					res_gr_d = grant_of(pos_q[AW-1:0]);
					res_st_d = ffba_pkg::STATUS_OK;
					st_d     = ST_RESP;
				end else if (walk_next < arena_q) begin
					pos_d   = walk_next;
					rd_addr = walk_next[AW-1:0];
				end else begin
					res_st_d = ffba_pkg::STATUS_NO_SPACE;
					st_d     = ST_RESP;
				end
			end
			ST_A_SPLIT: begin
				wr_en    = 1'b1;
				wr_addr  = nh_q;
				wr_data  = {2'b11, reqx[AW-1:0]};
				res_ok_d = 1'b1;
				res_gr_d = grant_of(nh_q);
				res_st_d = ffba_pkg::STATUS_OK;
				st_d     = ST_RESP;
			end
			ST_F_CHKH: begin
				if (!hv || !hb) begin
					res_st_d = ffba_pkg::STATUS_NOT_ALLOC;
					st_d     = ST_RESP;
				end else begin
					hsz_d = hs;
					if (walk_next < arena_q) begin
						pos_d   = walk_next;
						rd_addr = walk_next[AW-1:0];
						st_d    = ST_F_CHKN;
					end else if (h_q == '0) begin
						st_d = ST_F_WHDR;
					end else begin
						pos_d   = '0;
						rd_addr = '0;
						st_d    = ST_F_SCAN;
					end
				end
			end
			ST_F_CHKN: begin
				if (hv && !hb) begin
					// Swallow the free next block and drop its header.
					wr_en = 1'b1;
					hsz_d = merge_sum[AW-1:0];
				end
				if (h_q == '0) begin
					st_d = ST_F_WHDR;
				end else begin
					pos_d   = '0;
					rd_addr = '0;
					st_d    = ST_F_SCAN;
				end
			end
			ST_F_SCAN: begin
				if (!hv) begin
					st_d = ST_F_WHDR;
				end else if (walk_next == h_q) begin
					if (!hb) begin
						psz_d        = merge_sum[AW-1:0];
						merge_prev_d = 1'b1;
						st_d         = ST_F_WPREV;
					end else begin
						st_d = ST_F_WHDR;
					end
				end else begin
					pos_d   = walk_next;
					rd_addr = walk_next[AW-1:0];
					if (!(walk_next < h_q)) begin
						st_d = ST_F_WHDR;
					end
				end
			end
			ST_F_WPREV: begin
				wr_en   = 1'b1;
				wr_data = {2'b10, psz_q};
				st_d    = ST_F_WHDR;
			end
			ST_F_WHDR: begin
				wr_en    = 1'b1;
				wr_addr  = h_q[AW-1:0];
				wr_data  = merge_prev_q ? '0 : {2'b10, hsz_q};
				res_ok_d = 1'b1;
				res_gr_d = '0;
				res_st_d = ffba_pkg::STATUS_OK;
				st_d     = ST_RESP;
			end
			ST_RESP: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_CLEAR;
				clr_d = '0;
			end
		endcase
		if (cfg_we) begin
			st_d  = ST_CLEAR;
			clr_d = '0;
		end
	end

	// Saturate the written arena size into the supported range.
	logic [VW-1:0] cfg_v, cfg_sat;
	assign cfg_v = VW'(cfg_data);
	always_comb begin
		cfg_sat = cfg_v;
		if (cfg_v < VW'(2)) begin
			cfg_sat = VW'(2);
		end else if (cfg_v > VW'(ARENA_GRANULES)) begin
			cfg_sat = VW'(ARENA_GRANULES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			arena_q     <= CW'(ARENA_GRANULES);
			rsp_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_d;
			if (cfg_we) begin
				arena_q <= cfg_sat[CW-1:0];
			end
			if (st_q == ST_RESP && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		h_q          <= h_d;
		req_q        <= req_d;
		hsz_q        <= hsz_d;
		psz_q        <= psz_d;
		nh_q         <= nh_d;
		merge_prev_q <= merge_prev_d;
		res_ok_q     <= res_ok_d;
		res_gr_q     <= res_gr_d;
		res_st_q     <= res_st_d;
		if (st_q == ST_RESP && slot_free) begin
			rsp_ok_q <= res_ok_q;
			rsp_gr_q <= res_gr_q;
			rsp_st_q <= res_st_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.ok              = rsp_ok_q;
	assign rsp.granted_granule = rsp_gr_q;
	assign rsp.status          = rsp_st_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !wr_en)
		else $error("header memory written while idle");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (st_q == ST_CLEAR) && (clr_q == '0))
		else $error("configuration write did not restart the clearing pass");

	a_walk_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_A_CHK) |-> (pos_q < arena_q))
		else $error("allocate walk left the arena");

	a_scan_before_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_F_SCAN) |-> (pos_q < h_q))
		else $error("previous-block scan passed the freed header");

	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_ok_q == (rsp_st_q == ffba_pkg::STATUS_OK)))
		else $error("response ok flag disagrees with status");

endmodule
`default_nettype wire
